/* rtl/chss_pkg.sv */
// types and constants shared by the cubic hermite segment sampler
// no dependencies
package chss_pkg;

	// field widths
	localparam int FIELD_W  = 24;
	localparam int IN_W     = 9 * FIELD_W;
	localparam int OUT_W    = 3 * FIELD_W;
	localparam int SPEED_W  = 16;
	localparam int CFG_W    = 24;
	localparam int ADDR_W   = 2;

	// datapath widths
	localparam int MUL_A_W  = 32;
	localparam int MUL_B_W  = 25;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int RAD_W    = 50;
	localparam int COEF_W   = 48;
	localparam int ACC_W    = 52;
	localparam int DIV_CW   = 6;

	// register indexes
	localparam logic [ADDR_W-1:0] REG_TRAVEL_SPEED  = 2'd0;
	localparam logic [ADDR_W-1:0] REG_SAMPLE_PERIOD = 2'd1;
	localparam logic [ADDR_W-1:0] REG_FLIGHT_HEIGHT = 2'd2;

	// reset values
	localparam logic [SPEED_W-1:0] SPEED_RST  = 16'd256;
	localparam logic [SPEED_W-1:0] PERIOD_RST = 16'd26;
	localparam logic [FIELD_W-1:0] HEIGHT_RST = 24'd512;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_DX,
		OP_RAD_SET,
		OP_MUL_DY,
		OP_RAD_ADD,
		OP_SQRT_STEP,
		OP_DIVD_INIT,
		OP_DIV_STEP,
		OP_DUR_SET,
		OP_MUL_V,
		OP_DV_SET,
		OP_COEF,
		OP_EMIT0,
		OP_DIVS_INIT,
		OP_S_SET,
		OP_ACC_INIT,
		OP_MUL_HI,
		OP_MUL_LO,
		OP_HORNER,
		OP_EMIT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_DX,
		ST_RAD_SET,
		ST_MUL_DY,
		ST_RAD_ADD,
		ST_SQRT,
		ST_DIVD_INIT,
		ST_DIV_D,
		ST_DUR_SET,
		ST_MUL_V,
		ST_DV_SET,
		ST_COEF,
		ST_EMIT0,
		ST_CHECK,
		ST_DIVS_INIT,
		ST_DIV_S,
		ST_S_SET,
		ST_ACC_INIT,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_HORNER,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] sel;
		logic       axis;
	} cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic div_done;
		logic loop_more;
	} stat_t;

endpackage

/* rtl/chss_datapath.sv */
// datapath of the segment sampler: sqrt, divider, shared multiplier, coefficients
// and horner evaluation; depends on chss_pkg
module chss_datapath #(
	parameter int MAX_POINTS = 64
) (
	input  logic                                   clk,
	input  chss_pkg::cmd_t                         cmd,
	output chss_pkg::stat_t                        stat,
	input  logic [chss_pkg::IN_W-1:0]              in_data,
	input  logic [chss_pkg::SPEED_W-1:0]           travel_speed,
	input  logic [chss_pkg::SPEED_W-1:0]           sample_period,
	input  logic [chss_pkg::FIELD_W-1:0]           flight_height,
	output logic [chss_pkg::OUT_W-1:0]             out_data,
	output logic                                   out_last,
	output logic                                   out_trunc
);
	import chss_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);

	// item registers
	logic signed [FIELD_W-1:0] bx_q, by_q, bz_q;
	logic signed [FIELD_W:0]   dx_q, dy_q;
	logic signed [FIELD_W-1:0] v_q [4];
	// arithmetic registers
	logic [PROD_W-1:0]         prod_q, hi_q;
	logic [RAD_W-1:0]          rad_q, res_q, bit_q;
	logic [31:0]               rem_q, dsr_q, dur_q, s_q;
	logic [32:0]               dvd_q, quo_q, t_q;
	logic [DIV_CW-1:0]         cnt_q;
	logic signed [COEF_W:0]    dv_q [4];
	logic signed [COEF_W-1:0]  cx_q [3];
	logic signed [COEF_W-1:0]  cy_q [3];
	logic signed [ACC_W-1:0]   accx_q, accy_q;
	logic [CW-1:0]             n_q;
	logic [FIELD_W-1:0]        ox_q, oy_q, oz_q;
	logic                      last_q, trunc_q;

	logic [SPEED_W-1:0]        speed_eff, period_eff;
	logic [FIELD_W:0]          absdx, absdy;
	logic [FIELD_W-1:0]        absv;
	logic signed [ACC_W-1:0]   acc_sel, accm;
	logic                      acc_neg;
	logic [MUL_A_W-1:0]        mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic [RAD_W-1:0]          sq_sum;
	logic [32:0]               r2, dsr_x;
	logic                      ge;
	logic [COEF_W-1:0]         dvmag;
	logic [PROD_W:0]           hsum;
	logic signed [ACC_W-1:0]   r_s, cval, acc_new;
	logic [32:0]               t_next;
	logic                      more, last_c;

	function automatic logic signed [COEF_W-1:0] clamp48(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi, lo;
		hi = ACC_W'(signed'({1'b0, {(COEF_W-1){1'b1}}}));
		lo = -hi - ACC_W'(1);
		if (v > hi) return hi[COEF_W-1:0];
		else if (v < lo) return lo[COEF_W-1:0];
		else return v[COEF_W-1:0];
	endfunction

	function automatic logic [FIELD_W-1:0] clamp24(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi, lo;
		hi = ACC_W'(signed'({1'b0, {(FIELD_W-1){1'b1}}}));
		lo = -hi - ACC_W'(1);
		if (v > hi) return hi[FIELD_W-1:0];
		else if (v < lo) return lo[FIELD_W-1:0];
		else return v[FIELD_W-1:0];
	endfunction

	// zero registers behave as one
	assign speed_eff  = (travel_speed == '0) ? SPEED_W'(1) : travel_speed;
	assign period_eff = (sample_period == '0) ? SPEED_W'(1) : sample_period;

	// magnitudes for the unsigned multiplier
	assign absdx   = dx_q[FIELD_W] ? -dx_q : dx_q;
	assign absdy   = dy_q[FIELD_W] ? -dy_q : dy_q;
	assign absv    = v_q[cmd.sel][FIELD_W-1] ? -v_q[cmd.sel] : v_q[cmd.sel];
	assign acc_sel = cmd.axis ? accy_q : accx_q;
	assign acc_neg = acc_sel[ACC_W-1];
	assign accm    = acc_neg ? -acc_sel : acc_sel;

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = s_q;
		mul_b = accm[MUL_B_W-1:0];
		case (cmd.op)
			OP_MUL_DX: begin
				mul_a = MUL_A_W'(absdx);
				mul_b = absdx;
			end
			OP_MUL_DY: begin
				mul_a = MUL_A_W'(absdy);
				mul_b = absdy;
			end
			OP_MUL_V: begin
				mul_a = dur_q;
				mul_b = MUL_B_W'(absv);
			end
			OP_MUL_HI: begin
				mul_a = s_q;
				mul_b = accm[2*MUL_B_W-1:MUL_B_W];
			end
			default: begin
				mul_a = s_q;
				mul_b = accm[MUL_B_W-1:0];
			end
		endcase
	end

	// sqrt, divider and horner step logic
	assign sq_sum  = res_q + bit_q;
	assign r2      = {rem_q, dvd_q[32]};
	assign dsr_x   = {1'b0, dsr_q};
	assign ge      = (r2 >= dsr_x);
	assign dvmag   = prod_q[COEF_W+7:8];
	assign hsum    = {1'b0, hi_q} + (PROD_W+1)'(prod_q >> MUL_B_W);
	assign r_s     = ACC_W'(hsum >> 7);
	assign acc_new = cval + (acc_neg ? -r_s : r_s);
	assign t_next  = t_q + 33'(period_eff);
	assign more    = t_next < {1'b0, dur_q};
	assign last_c  = !more || ((CW + 1)'(n_q) + (CW + 1)'(1) >= (CW + 1)'(MAX_POINTS));

	always_comb begin
		if (cmd.sel == 2'd0)
			cval = ACC_W'(cmd.axis ? by_q : bx_q);
		else if (cmd.axis)
			cval = ACC_W'(cy_q[cmd.sel - 2'd1]);
		else
			cval = ACC_W'(cx_q[cmd.sel - 2'd1]);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				bx_q   <= in_data[0*FIELD_W +: FIELD_W];
				by_q   <= in_data[1*FIELD_W +: FIELD_W];
				bz_q   <= in_data[2*FIELD_W +: FIELD_W];
				dx_q   <= (FIELD_W+1)'(signed'(in_data[3*FIELD_W +: FIELD_W]))
					- (FIELD_W+1)'(signed'(in_data[0*FIELD_W +: FIELD_W]));
				dy_q   <= (FIELD_W+1)'(signed'(in_data[4*FIELD_W +: FIELD_W]))
					- (FIELD_W+1)'(signed'(in_data[1*FIELD_W +: FIELD_W]));
				v_q[0] <= in_data[5*FIELD_W +: FIELD_W];
				v_q[1] <= in_data[7*FIELD_W +: FIELD_W];
				v_q[2] <= in_data[6*FIELD_W +: FIELD_W];
				v_q[3] <= in_data[8*FIELD_W +: FIELD_W];
			end
			OP_MUL_DX, OP_MUL_DY, OP_MUL_V, OP_MUL_HI: begin
				prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
			end
			OP_MUL_LO: begin
				hi_q   <= prod_q;
				prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
			end
			OP_RAD_SET: rad_q <= prod_q[RAD_W-1:0];
			OP_RAD_ADD: begin
				rad_q <= rad_q + prod_q[RAD_W-1:0];
				res_q <= '0;
				bit_q <= RAD_W'(1) << (RAD_W - 2);
			end
			OP_SQRT_STEP: begin
				if (rad_q >= sq_sum) begin
					rad_q <= rad_q - sq_sum;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_DIVD_INIT: begin
				rem_q <= '0;
				dvd_q <= {res_q[24:0], 8'b0};
				dsr_q <= 32'(speed_eff);
				cnt_q <= DIV_CW'(33);
				quo_q <= '0;
			end
			OP_DIVS_INIT: begin
				rem_q <= t_q[31:0];
				dvd_q <= '0;
				dsr_q <= dur_q;
				cnt_q <= DIV_CW'(32);
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= ge ? 32'(r2 - dsr_x) : r2[31:0];
				quo_q <= {quo_q[31:0], ge};
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q - DIV_CW'(1);
			end
			OP_DUR_SET: dur_q <= quo_q[32] ? '1 : quo_q[31:0];
			OP_S_SET: s_q <= quo_q[31:0];
			OP_DV_SET: begin
				dv_q[cmd.sel] <= v_q[cmd.sel][FIELD_W-1] ?
					-signed'({1'b0, dvmag}) : signed'({1'b0, dvmag});
			end
			OP_COEF: begin
				cx_q[0] <= clamp48(ACC_W'(dv_q[0]));
				cx_q[1] <= clamp48(ACC_W'(dx_q) * 3 - ACC_W'(dv_q[0]) * 2 - ACC_W'(dv_q[1]));
				cx_q[2] <= clamp48(-(ACC_W'(dx_q) * 2) + ACC_W'(dv_q[0]) + ACC_W'(dv_q[1]));
				cy_q[0] <= clamp48(ACC_W'(dv_q[2]));
				cy_q[1] <= clamp48(ACC_W'(dy_q) * 3 - ACC_W'(dv_q[2]) * 2 - ACC_W'(dv_q[3]));
				cy_q[2] <= clamp48(-(ACC_W'(dy_q) * 2) + ACC_W'(dv_q[2]) + ACC_W'(dv_q[3]));
			end
			OP_EMIT0: begin
				ox_q    <= bx_q;
				oy_q    <= by_q;
				oz_q    <= bz_q;
				last_q  <= (33'(period_eff) >= {1'b0, dur_q});
				trunc_q <= 1'b0;
				n_q     <= CW'(1);
				t_q     <= 33'(period_eff);
			end
			OP_ACC_INIT: begin
				accx_q <= ACC_W'(cx_q[2]);
				accy_q <= ACC_W'(cy_q[2]);
			end
			OP_HORNER: begin
				if (cmd.axis) accy_q <= acc_new;
				else accx_q <= acc_new;
			end
			OP_EMIT: begin
				ox_q    <= clamp24(accx_q);
				oy_q    <= clamp24(accy_q);
				oz_q    <= flight_height;
				last_q  <= last_c;
				trunc_q <= last_c && more;
				n_q     <= n_q + CW'(1);
				t_q     <= t_next;
			end
			default: ;
		endcase
	end

	assign stat.sqrt_done = (bit_q == '0);
	assign stat.div_done  = (cnt_q == '0);
	assign stat.loop_more = (t_q < {1'b0, dur_q}) && (n_q < CW'(MAX_POINTS));

	assign out_data  = {oz_q, oy_q, ox_q};
	assign out_last  = last_q;
	assign out_trunc = trunc_q;

endmodule

/* rtl/chss_ctrl.sv */
// controller of the segment sampler: sequences the datapath and the stream handshakes
// depends on chss_pkg
module chss_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  chss_pkg::stat_t stat,
	output chss_pkg::cmd_t  cmd
);
	import chss_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] sel_q, sel_d;
	logic       axis_q, axis_d;
	logic       valid_q, valid_d;
	logic       out_free;

	assign out_free = !valid_q || m_tready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= '0;
			axis_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			axis_q  <= axis_d;
			valid_q <= valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		sel_d    = sel_q;
		axis_d   = axis_q;
		valid_d  = m_tready ? 1'b0 : valid_q;
		cmd.op   = OP_NONE;
		cmd.sel  = sel_q;
		cmd.axis = axis_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_MUL_DX;
				end
			end
			ST_MUL_DX: begin
				cmd.op  = OP_MUL_DX;
				state_d = ST_RAD_SET;
			end
			ST_RAD_SET: begin
				cmd.op  = OP_RAD_SET;
				state_d = ST_MUL_DY;
			end
			ST_MUL_DY: begin
				cmd.op  = OP_MUL_DY;
				state_d = ST_RAD_ADD;
			end
			ST_RAD_ADD: begin
				cmd.op  = OP_RAD_ADD;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (stat.sqrt_done) state_d = ST_DIVD_INIT;
				else cmd.op = OP_SQRT_STEP;
			end
			ST_DIVD_INIT: begin
				cmd.op  = OP_DIVD_INIT;
				state_d = ST_DIV_D;
			end
			ST_DIV_D: begin
				if (stat.div_done) state_d = ST_DUR_SET;
				else cmd.op = OP_DIV_STEP;
			end
			ST_DUR_SET: begin
				cmd.op  = OP_DUR_SET;
				sel_d   = 2'd0;
				state_d = ST_MUL_V;
			end
			ST_MUL_V: begin
				cmd.op  = OP_MUL_V;
				state_d = ST_DV_SET;
			end
			ST_DV_SET: begin
				cmd.op = OP_DV_SET;
				if (sel_q == 2'd3) begin
					state_d = ST_COEF;
				end else begin
					sel_d   = sel_q + 2'd1;
					state_d = ST_MUL_V;
				end
			end
			ST_COEF: begin
				cmd.op  = OP_COEF;
				state_d = ST_EMIT0;
			end
			ST_EMIT0: begin
				if (out_free) begin
					cmd.op  = OP_EMIT0;
					valid_d = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = stat.loop_more ? ST_DIVS_INIT : ST_IDLE;
			end
			ST_DIVS_INIT: begin
				cmd.op  = OP_DIVS_INIT;
				state_d = ST_DIV_S;
			end
			ST_DIV_S: begin
				if (stat.div_done) state_d = ST_S_SET;
				else cmd.op = OP_DIV_STEP;
			end
			ST_S_SET: begin
				cmd.op  = OP_S_SET;
				state_d = ST_ACC_INIT;
			end
			ST_ACC_INIT: begin
				cmd.op  = OP_ACC_INIT;
				sel_d   = 2'd2;
				axis_d  = 1'b0;
				state_d = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.op  = OP_MUL_HI;
				state_d = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				cmd.op  = OP_MUL_LO;
				state_d = ST_HORNER;
			end
			ST_HORNER: begin
				cmd.op = OP_HORNER;
				if (sel_q != 2'd0) begin
					sel_d   = sel_q - 2'd1;
					state_d = ST_MUL_HI;
				end else if (!axis_q) begin
					axis_d  = 1'b1;
					sel_d   = 2'd2;
					state_d = ST_MUL_HI;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.op  = OP_EMIT;
					valid_d = 1'b1;
					state_d = ST_CHECK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = valid_q;

endmodule

/* rtl/cubic_hermite_segment_sampler_unit.sv */
// Cubic hermite segment sampler. Takes one path segment per item and returns its
// start point followed by curve samples at each multiple of the sample period below
// the segment duration. Work is sequential, one segment at a time: the start point is
// offered after 25 square-root steps, a 33-step duration divide and four velocity
// products on one shared 32x25 multiplier; each sampled point then takes a 32-step
// divide for the curve parameter plus six two-part horner products (high product, low
// product, horner step), and a check state then picks the next sample or idle. The
// point count is capped at MAX_POINTS; the output register lets the next point be
// computed while one waits. Depends on chss_pkg, chss_ctrl and chss_datapath.
module cubic_hermite_segment_sampler_unit #(
	parameter int MAX_POINTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// begin_x, begin_y, begin_z, end_x, end_y, start_vel_x, start_vel_y,
	// finish_vel_x, finish_vel_y
	input  logic [chss_pkg::IN_W-1:0]     s_tdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// point_x, point_y, point_z
	output logic [chss_pkg::OUT_W-1:0]    m_tdata,
	output logic                          m_tlast,
	// truncated
	output logic                          m_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          cfg_we,
	input  logic [chss_pkg::ADDR_W-1:0]   cfg_addr,
	input  logic [chss_pkg::CFG_W-1:0]    cfg_data
);
	import chss_pkg::*;

	logic [SPEED_W-1:0] travel_speed_q, sample_period_q;
	logic [FIELD_W-1:0] flight_height_q;
	cmd_t               cmd;
	stat_t              stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_speed_q  <= SPEED_RST;
			sample_period_q <= PERIOD_RST;
			flight_height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_TRAVEL_SPEED:  travel_speed_q  <= cfg_data[SPEED_W-1:0];
				REG_SAMPLE_PERIOD: sample_period_q <= cfg_data[SPEED_W-1:0];
				REG_FLIGHT_HEIGHT: flight_height_q <= cfg_data[FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	chss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	chss_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.stat          (stat),
		.in_data       (s_tdata),
		.travel_speed  (travel_speed_q),
		.sample_period (sample_period_q),
		.flight_height (flight_height_q),
		.out_data      (m_tdata),
		.out_last      (m_tlast),
		.out_trunc     (m_tuser)
	);

	// an accepted segment keeps the input closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input open right after accepting a segment");

	// truncation is flagged only on the final point of a segment
	a_trunc_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("truncated set on a point that is not the last");

	// a new segment is only taken once the final point of the previous one is offered
	a_no_accept_mid_segment: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("segment accepted while points of the previous one remain");

endmodule

/* dv/cubic_hermite_segment_sampler_unit_tb.sv */
// self-checking testbench for cubic_hermite_segment_sampler_unit
// predicts every sampled point in place and compares items on the output stream
// depends on chss_pkg and the sampler rtl
module cubic_hermite_segment_sampler_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import chss_pkg::*;

	localparam int CAP_POINTS = 64;

	typedef struct {
		logic signed [23:0] bx, by, bz, ex, ey, v0x, v0y, v1x, v1y;
	} segment_t;

	typedef struct {
		logic [23:0] x, y, z;
		logic        last, trunc;
	} point_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic [IN_W-1:0]     s_tdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic                m_tlast, m_tuser, m_tvalid;
	logic                m_tready = 1'b0;
	logic                cfg_we = 1'b0;
	logic [ADDR_W-1:0]   cfg_addr = REG_TRAVEL_SPEED;
	logic [CFG_W-1:0]    cfg_data = '0;

	// predictor copy of the registers
	logic [15:0] speed_q = SPEED_RST;
	logic [15:0] period_q = PERIOD_RST;
	logic [23:0] height_q = HEIGHT_RST;

	point_t pending_points[$];
	int     mismatch_count = 0;
	int     ready_pct = 100;
	bit     gaps_on = 1'b1;
	int     burst_left = 0;

	cubic_hermite_segment_sampler_unit #(.MAX_POINTS(CAP_POINTS)) dut (.*);

	always #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic longint clamp_to(longint v, int bits);
		longint lim;
		lim = longint'(1) <<< (bits - 1);
		if (v > lim - 1) return lim - 1;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n) bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	// product with a q0.32 fraction, truncated toward zero
	function automatic longint frac_mul(longint c, logic [31:0] s);
		logic [127:0] m;
		m = (c < 0) ? 128'(-c) : 128'(c);
		m = (m * 128'(s)) >> 32;
		return (c < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint scale_vel(logic [31:0] d, longint v);
		longint p;
		p = longint'({32'd0, d}) * v;
		return (p < 0) ? -((-p) >>> 8) : (p >>> 8);
	endfunction

	function automatic void hermite_coefs(longint p0, longint p1, longint v0, longint v1,
			logic [31:0] d, output longint c[4]);
		longint dp, dv0, dv1;
		dp = p1 - p0;
		dv0 = scale_vel(d, v0);
		dv1 = scale_vel(d, v1);
		c[0] = p0;
		c[1] = clamp_to(dv0, 48);
		c[2] = clamp_to(3 * dp - 2 * dv0 - dv1, 48);
		c[3] = clamp_to(-2 * dp + dv0 + dv1, 48);
	endfunction

	function automatic logic [23:0] horner(longint c[4], logic [31:0] s);
		longint acc;
		acc = c[3];
		acc = c[2] + frac_mul(acc, s);
		acc = c[1] + frac_mul(acc, s);
		acc = c[0] + frac_mul(acc, s);
		return 24'(clamp_to(acc, 24));
	endfunction

	// works out every point a segment produces and queues it
	task automatic predict_segment(segment_t g);
		longint dx, dy, cx[4], cy[4];
		longint unsigned seg_len, dur, t, per, nxt;
		logic [31:0] s;
		int n;
		point_t p;
		bit more;
		dx = longint'(g.ex) - longint'(g.bx);
		dy = longint'(g.ey) - longint'(g.by);
		seg_len = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
		dur = (seg_len << 8) / ((speed_q == 0) ? 1 : speed_q);
		if (dur > 64'hFFFF_FFFF) dur = 64'hFFFF_FFFF;
		per = (period_q == 0) ? 1 : period_q;
		hermite_coefs(g.bx, g.ex, g.v0x, g.v1x, dur[31:0], cx);
		hermite_coefs(g.by, g.ey, g.v0y, g.v1y, dur[31:0], cy);
		t = per;
		p.x = g.bx;
		p.y = g.by;
		p.z = g.bz;
		p.last = (t >= dur);
		p.trunc = 1'b0;
		pending_points = {pending_points, p};
		n = 1;
		while (t < dur && n < CAP_POINTS) begin
			s = 32'((t << 32) / dur);
			nxt = t + per;
			more = nxt < dur;
			p.x = horner(cx, s);
			p.y = horner(cy, s);
			p.z = height_q;
			p.last = !more || (n + 1 >= CAP_POINTS);
			p.trunc = p.last && more;
			pending_points = {pending_points, p};
			n++;
			t = nxt;
		end
	endtask

	task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// output side: random stalls, every accepted item checked against the oldest point
	always @(posedge clk) begin
		point_t w;
		if (m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				report_mismatch("unexpected item", m_tdata[23:0], '0);
			end else begin
				w = pending_points.pop_front();
				if (m_tdata[23:0] !== w.x) report_mismatch("point_x", m_tdata[23:0], w.x);
				if (m_tdata[47:24] !== w.y) report_mismatch("point_y", m_tdata[47:24], w.y);
				if (m_tdata[71:48] !== w.z) report_mismatch("point_z", m_tdata[71:48], w.z);
				if (m_tlast !== w.last) report_mismatch("last_point", m_tlast, w.last);
				if (m_tuser !== w.trunc) report_mismatch("truncated", m_tuser, w.trunc);
			end
		end
		m_tready <= ($urandom_range(0, 99) < ready_pct);
	end

	task automatic write_reg(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_TRAVEL_SPEED:  speed_q = val[15:0];
			REG_SAMPLE_PERIOD: period_q = val[15:0];
			REG_FLIGHT_HEIGHT: height_q = val;
			default: ;
		endcase
	endtask

	// waits until every predicted point is out, then lets the pipeline settle
	task automatic drain_points();
		while (pending_points.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_config(logic [15:0] spd, logic [15:0] per, logic [23:0] hgt);
		drain_points();
		write_reg(REG_TRAVEL_SPEED, {8'd0, spd});
		write_reg(REG_SAMPLE_PERIOD, {8'd0, per});
		write_reg(REG_FLIGHT_HEIGHT, hgt);
	endtask

	// sends one segment item; with gaps on, a gap follows when a burst runs out
	task automatic send_segment(segment_t g);
		int gap;
		s_tdata <= {g.v1y, g.v1x, g.v0y, g.v0x, g.ey, g.ex, g.bz, g.by, g.bx};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_segment(g);
		if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 8);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic end_burst();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic segment_t make_segment(longint bx, longint by, longint ex,
			longint ey, longint vel);
		segment_t g;
		g.bx = 24'(bx);
		g.by = 24'(by);
		g.bz = 24'($urandom);
		g.ex = 24'(ex);
		g.ey = 24'(ey);
		g.v0x = 24'(vel);
		g.v0y = 24'(-vel);
		g.v1x = 24'(-vel);
		g.v1y = 24'(vel);
		return g;
	endfunction

	function automatic segment_t random_segment();
		segment_t g;
		int k;
		k = $urandom_range(0, 99);
		g.bx = 24'($urandom);
		g.by = 24'($urandom);
		g.bz = 24'($urandom);
		if (k < 80) begin
			g.ex = 24'(longint'(g.bx) + $urandom_range(0, 2046) - 1023);
			g.ey = 24'(longint'(g.by) + $urandom_range(0, 2046) - 1023);
		end else begin
			g.ex = 24'($urandom);
			g.ey = 24'($urandom);
		end
		if (k % 2 == 0) begin
			g.v0x = 24'($urandom);
			g.v0y = 24'($urandom);
			g.v1x = 24'($urandom);
			g.v1y = 24'($urandom);
		end else begin
			g.v0x = 24'($urandom_range(0, 4095) - 2048);
			g.v0y = 24'($urandom_range(0, 4095) - 2048);
			g.v1x = 24'($urandom_range(0, 4095) - 2048);
			g.v1y = 24'($urandom_range(0, 4095) - 2048);
		end
		return g;
	endfunction

	// reset values: zero length, exact period multiple, one past it, short curves
	task automatic test_default_config();
		gaps_on = 1'b0;
		ready_pct = 100;
		send_segment(make_segment(100, -50, 100, -50, 0));
		send_segment(make_segment(0, 0, 260, 0, 0));
		send_segment(make_segment(0, 0, 261, 0, 0));
		send_segment(make_segment(-300, 200, 0, 600, 512));
		send_segment(make_segment(0, 0, 0, -130, -8388608));
		send_segment(make_segment(5, 5, 5 + 180, 5 - 240, 8388607));
		end_burst();
	endtask

	// register extremes with corner-to-corner segments, saturation and the point cap
	task automatic test_extremes();
		gaps_on = 1'b1;
		ready_pct = 60;
		set_config(16'd1, 16'hFFFF, 24'h800000);
		send_segment(make_segment(-8388608, -8388608, 8388607, 8388607, 8388607));
		send_segment(make_segment(8388607, -8388608, -8388608, 8388607, -8388608));
		send_segment(make_segment(0, 0, 0, 0, 8388607));
		send_segment(make_segment(0, 0, 1, 0, 0));
		send_segment(make_segment(-8388608, 0, -8388608 + 512, 300, 1000));
		end_burst();
		set_config(16'hFFFF, 16'd1, 24'h7FFFFF);
		send_segment(make_segment(-8388608, -8388608, 8388607, 8388607, -8388608));
		send_segment(make_segment(0, 8388607, 0, -8388608, 8388607));
		send_segment(make_segment(0, 0, 1024, 1024, 8388607));
		send_segment(make_segment(1, 1, 2, 2, -1));
		send_segment(make_segment(-1, -1, -1, -1, -1));
		end_burst();
		set_config(16'd256, 16'd26, 24'hFFFFFF);
		send_segment(make_segment(-8388608, 0, 8388607, 0, 0));
		send_segment(make_segment(0, 0, 26 * 63, 0, 0));
		send_segment(make_segment(0, 0, 26 * 64, 0, 0));
		send_segment(make_segment(0, 0, 26 * 64 + 1, 0, 8388607));
		end_burst();
	endtask

	// random segments under several settings and handshake patterns
	task automatic test_random_segments();
		int ph;
		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_config(16'd256, 16'd200, 24'($urandom));
				1: set_config(16'hFFFF, 16'd1, 24'($urandom));
				2: set_config(16'd1, 16'hFFFF, 24'($urandom));
				3: set_config(16'($urandom_range(64, 2048)), 16'($urandom_range(100, 900)),
						24'($urandom));
				default: set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(150, 65535)),
						24'($urandom));
			endcase
			gaps_on = (ph != 2);
			ready_pct = (ph == 1) ? 100 : $urandom_range(30, 95);
			repeat (62) send_segment(random_segment());
			end_burst();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_default_config();
		test_extremes();
		test_random_segments();
		drain_points();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && pending_points.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/chss_pkg.sv
rtl/chss_datapath.sv
rtl/chss_ctrl.sv
rtl/cubic_hermite_segment_sampler_unit.sv
dv/cubic_hermite_segment_sampler_unit_tb.sv
